// ===== src/cpdec_pkg.sv =====
// Shared types, codes and constants of the cp932 decoder.
package cpdec_pkg;

	// defaults for the top-level parameters
	localparam int LEAD_ROWS_DEF   = 64;
	localparam int TRAIL_FIRST_DEF = 64;
	localparam int TRAIL_LAST_DEF  = 252;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0]  ASCII_LIMIT = 8'h80;
	localparam logic [7:0]  KANA_FIRST  = 8'hA1;
	localparam logic [7:0]  KANA_LAST   = 8'hDF;
	localparam logic [15:0] KANA_BASE   = 16'hFF61;
	localparam logic [15:0] REPLACEMENT = 16'hFFFD;

	// opcodes
	localparam logic [1:0] OP_DECODE    = 2'd0;
	localparam logic [1:0] OP_LOAD_ROW  = 2'd1;
	localparam logic [1:0] OP_LOAD_CODE = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  data_byte;
		logic [5:0]  row_index;
		logic [7:0]  column_index;
		logic [15:0] table_code;
	} cmd_t;

	typedef struct packed {
		logic [15:0] code_point;
		logic        end_of_text;
		logic        last;
	} res_t;

	// what the back has to do with a queued command
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_ROW,
		ACT_CODE,
		ACT_BYTE
	} act_t;

	// class of a byte seen with nothing pending
	typedef enum logic [1:0] {
		CLS_EOT,
		CLS_CHAR,
		CLS_LEAD
	} cls_t;

	typedef struct packed {
		act_t        act;
		cls_t        cls;
		logic [15:0] cp;         // code point for a single-byte character
		logic [7:0]  data;       // text byte or lead value
		logic        trail_ok;   // byte lies in the trail range
		logic [5:0]  row;
		logic [7:0]  col;        // trail offset
		logic [15:0] table_code;
	} ent_t;

endpackage

// ===== src/cpdec_front.sv =====
// Front: classifies each incoming command into a queue entry.
module cpdec_front import cpdec_pkg::*; #(
	parameter int LEAD_ROWS   = LEAD_ROWS_DEF,
	parameter int TRAIL_FIRST = TRAIL_FIRST_DEF,
	parameter int TRAIL_LAST  = TRAIL_LAST_DEF
) (
	input  cmd_t cmd,
	output ent_t ent
);

	localparam int Span = TRAIL_LAST - TRAIL_FIRST + 1;
	localparam logic [7:0] TrailFirst8 = 8'(TRAIL_FIRST);
	localparam logic [7:0] TrailLast8  = 8'(TRAIL_LAST);

	logic row_ok;
	logic col_ok;

	assign row_ok = 32'(cmd.row_index) < 32'(LEAD_ROWS);
	assign col_ok = (Span > 0) && (32'(cmd.column_index) < 32'(Span));

	always_comb begin
		ent            = '0;
		ent.data       = cmd.data_byte;
		ent.row        = cmd.row_index;
		ent.table_code = cmd.table_code;
		ent.trail_ok   = (cmd.data_byte >= TrailFirst8) && (cmd.data_byte <= TrailLast8);

		if (cmd.data_byte == 8'd0) begin
			ent.cls = CLS_EOT;
			ent.cp  = '0;
		end else if (cmd.data_byte < ASCII_LIMIT) begin
			ent.cls = CLS_CHAR;
			ent.cp  = {8'd0, cmd.data_byte};
		end else if (cmd.data_byte inside {[KANA_FIRST:KANA_LAST]}) begin
			ent.cls = CLS_CHAR;
			ent.cp  = KANA_BASE + 16'(cmd.data_byte - KANA_FIRST);
		end else begin
			ent.cls = CLS_LEAD;
			ent.cp  = '0;
		end

		case (cmd.opcode)
			OP_DECODE: begin
				ent.act = ACT_BYTE;
				ent.col = cmd.data_byte - TrailFirst8;
			end
			OP_LOAD_ROW: begin
				ent.act = row_ok ? ACT_ROW : ACT_NONE;
			end
			OP_LOAD_CODE: begin
				ent.act = (row_ok && col_ok) ? ACT_CODE : ACT_NONE;
				ent.col = cmd.column_index;
			end
			default: begin
				ent.act = ACT_NONE;
			end
		endcase
	end

endmodule

// ===== src/cpdec_queue.sv =====
// Short FIFO of classified entries between front and back.
module cpdec_queue import cpdec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic full,
	input  ent_t push_ent,
	input  logic pop,
	output logic empty,
	output ent_t head
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	ent_t            slot_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            take;

	assign full  = count_q == CntW'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign push  = push_valid && !full;
	assign take  = pop && !empty;
	assign head  = slot_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (take) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_ent;
	end

endmodule

// ===== src/cpdec_back.sv =====
// Back: lead-row match, code memory, pending-lead state and result register.
module cpdec_back import cpdec_pkg::*; #(
	parameter int LEAD_ROWS   = LEAD_ROWS_DEF,
	parameter int TRAIL_FIRST = TRAIL_FIRST_DEF,
	parameter int TRAIL_LAST  = TRAIL_LAST_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  ent_t head,
	input  logic empty,
	output logic pop,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int Span     = TRAIL_LAST - TRAIL_FIRST + 1;
	localparam int MemDepth = LEAD_ROWS * ((Span > 0) ? Span : 1);
	localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
	localparam int RowW     = (LEAD_ROWS > 1) ? $clog2(LEAD_ROWS) : 1;
	localparam int NGrp     = (LEAD_ROWS + 7) / 8;
	localparam int GrpW     = (NGrp > 1) ? $clog2(NGrp) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEL,
		S_REJ,
		S_READ,
		S_DATA,
		S_EMIT
	} state_t;

	state_t          state_q;
	logic            lead_pending_q;
	logic [7:0]      held_lead_q;
	logic            two_q;
	logic            out_valid_q;
	res_t            out_q;
	res_t            res0_q;
	res_t            res1_q;
	ent_t            cur_q;
	logic [RowW-1:0] hit_row_q;

	logic [7:0]      lead_rows_q [LEAD_ROWS];
	logic [15:0]     code_mem [MemDepth];
	logic [15:0]     rdata_q;

	logic [NGrp*8-1:0] match_pad;
	logic [NGrp-1:0]   grp_any;
	logic [2:0]        grp_idx [NGrp];
	logic [NGrp-1:0]   grp_any_q;
	logic [2:0]        grp_idx_q [NGrp];
	logic              sel_hit;
	logic [GrpW-1:0]   sel_grp;
	logic [RowW-1:0]   hit_row;

	logic [RowW-1:0]   addr_row;
	logic [7:0]        addr_col;
	logic [AddrW-1:0]  mem_addr;
	logic              mem_we;
	logic              mem_re;
	logic              out_free;
	logic              push;

	function automatic res_t char_of(input ent_t e);
		return '{code_point: e.cp, end_of_text: (e.cls == CLS_EOT), last: 1'b0};
	endfunction

	assign pop      = (state_q == S_IDLE) && !empty;
	assign out_free = !out_valid_q || !res_stall;
	assign push     = (state_q == S_EMIT) && out_free;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// lead-row match, first level: compare all rows, priority inside groups of eight
	always_comb begin
		match_pad = '0;
		for (int r = 0; r < LEAD_ROWS; r++) begin
			match_pad[r] = lead_rows_q[r] == held_lead_q;
		end
	end

	always_comb begin
		for (int g = 0; g < NGrp; g++) begin
			grp_any[g] = |match_pad[g*8 +: 8];
			grp_idx[g] = 3'd0;
			for (int k = 7; k >= 0; k--) begin
				if (match_pad[g*8 + k]) grp_idx[g] = 3'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_q <= grp_any;
		for (int g = 0; g < NGrp; g++) begin
			grp_idx_q[g] <= grp_idx[g];
		end
	end

	// second level: lowest group wins
	always_comb begin
		sel_hit = |grp_any_q;
		sel_grp = '0;
		for (int g = NGrp - 1; g >= 0; g--) begin
			if (grp_any_q[g]) sel_grp = GrpW'(g);
		end
	end

	assign hit_row = RowW'({sel_grp, grp_idx_q[sel_grp]});

	// code memory: one address, shared by load writes and decode reads
	assign mem_we   = pop && (head.act == ACT_CODE);
	assign mem_re   = state_q == S_READ;
	assign addr_row = (state_q == S_READ) ? hit_row_q : RowW'(head.row);
	assign addr_col = (state_q == S_READ) ? cur_q.col : head.col;
	assign mem_addr = AddrW'(32'(addr_row) * 32'(Span) + 32'(addr_col));

	always_ff @(posedge clk) begin
		if (mem_we) code_mem[mem_addr] <= head.table_code;
		if (mem_re) rdata_q <= code_mem[mem_addr];
	end

	// lead rows; reset to zero so a row never loaded never matches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < LEAD_ROWS; r++) begin
				lead_rows_q[r] <= '0;
			end
		end else if (pop && (head.act == ACT_ROW)) begin
			lead_rows_q[RowW'(head.row)] <= head.data;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (state_q == S_SEL) hit_row_q <= hit_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			lead_pending_q <= 1'b0;
			held_lead_q    <= '0;
			two_q          <= 1'b0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
			res0_q         <= '0;
			res1_q         <= '0;
		end else begin
			if (out_free) out_valid_q <= push;
			if (push) begin
				out_q <= '{code_point: res0_q.code_point,
					end_of_text: res0_q.end_of_text, last: !two_q};
			end

			case (state_q)
				S_IDLE: begin
					if (pop && (head.act == ACT_BYTE)) begin
						if (lead_pending_q) begin
							lead_pending_q <= 1'b0;
							state_q        <= head.trail_ok ? S_SEL : S_REJ;
						end else if (head.cls == CLS_LEAD) begin
							lead_pending_q <= 1'b1;
							held_lead_q    <= head.data;
						end else begin
							res0_q  <= char_of(head);
							two_q   <= 1'b0;
							state_q <= S_EMIT;
						end
					end
				end
				S_SEL: begin
					state_q <= sel_hit ? S_READ : S_REJ;
				end
				S_READ: begin
					state_q <= S_DATA;
				end
				S_DATA: begin
					res0_q <= '{code_point: (rdata_q != '0) ? rdata_q : REPLACEMENT,
						end_of_text: 1'b0, last: 1'b0};
					two_q   <= 1'b0;
					state_q <= S_EMIT;
				end
				S_REJ: begin
					// rejected pair: replacement, then the trail as a fresh byte
					res0_q <= '{code_point: REPLACEMENT, end_of_text: 1'b0, last: 1'b0};
					if (cur_q.cls == CLS_LEAD) begin
						lead_pending_q <= 1'b1;
						held_lead_q    <= cur_q.data;
						two_q          <= 1'b0;
					end else begin
						res1_q <= char_of(cur_q);
						two_q  <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (push) begin
						if (two_q) begin
							res0_q <= res1_q;
							two_q  <= 1'b0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/cp932_to_unicode_decoder_core.sv =====
// Top level of the cp932 (Shift-JIS) to Unicode decoder.
//
// Takes one command per transfer on cmd and gives decoded code points on res. A decode
// command carries one text byte: bytes below 0x80 pass through, 0xA1..0xDF give half-width
// katakana from U+FF61, a zero byte with nothing pending gives an end-of-text marker
// (code point 0), and any other byte is held as a lead. The next decoded byte is its
// trail; the lead is matched against the loaded lead rows (lowest row wins) and the row
// plus trail offset pick a code memory entry. A bad trail or unmatched lead gives U+FFFD
// and the trail is then decoded again as a fresh byte, so one command may give two
// results; last marks the final one. A zero memory entry also gives U+FFFD. Lead rows and
// code entries are loaded with the load opcodes beforehand; out-of-range loads are
// dropped, and a code entry must be loaded before a decode reads it. No clearing pass is
// run after reset: lead rows reset to zero and so never match until loaded.
// Flow: commands enter a four-entry queue, so cmd_stall rises only when it is full.
// The back end takes one queued command at a time: a load or a held lead byte is done
// as it is taken, a single-byte character is taken and then loaded into the result
// register, a matched pair goes through a registered two-level match over the lead
// rows, one registered code memory read and the result, and a rejected pair gives the
// replacement and, for a trail that is no lead, a second result. Results wait in an
// output register, so a stalled res side holds the back end but not the queue.
module cp932_to_unicode_decoder_core import cpdec_pkg::*; #(
	parameter int LEAD_ROWS   = LEAD_ROWS_DEF,
	parameter int TRAIL_FIRST = TRAIL_FIRST_DEF,
	parameter int TRAIL_LAST  = TRAIL_LAST_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	ent_t front_ent;
	ent_t q_head;
	logic q_full;
	logic q_empty;
	logic q_pop;

	// stateless classification of every command
	cpdec_front #(
		.LEAD_ROWS  (LEAD_ROWS),
		.TRAIL_FIRST(TRAIL_FIRST),
		.TRAIL_LAST (TRAIL_LAST)
	) u_front (
		.cmd(cmd),
		.ent(front_ent)
	);

	// decouples input transfers from the back end
	cpdec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(cmd_valid),
		.full      (q_full),
		.push_ent  (front_ent),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	assign cmd_stall = q_full;

	// pending-lead state, lead-row match, code memory and result register
	cpdec_back #(
		.LEAD_ROWS  (LEAD_ROWS),
		.TRAIL_FIRST(TRAIL_FIRST),
		.TRAIL_LAST (TRAIL_LAST)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// only a rejected pair gives two results, and its first one is the replacement
	a_first_is_repl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> res.code_point == REPLACEMENT)
		else $error("non-final result is not U+FFFD");

	// the second result of a pair follows straight after the first transfer
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res.last |=> res_valid)
		else $error("second result missing after first transfer");

	// end-of-text marker carries code point zero and closes its command
	a_eot_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.end_of_text |-> res.last && res.code_point == '0)
		else $error("malformed end-of-text result");

endmodule
